// ===== sv/npd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package npd_pkg;

    // Command codes carried by a request.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Width of the reported point index.
    localparam int INDEX_W = 9;

    // Control tag that travels with each point through the distance unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } npd_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/npd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/npd_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npd_dist #(
    parameter int F  = 16,
    parameter int AW = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire npd_pkg::npd_ctrl_t    ctrl_in,
    input  wire logic [AW-1:0]         idx_in,
    input  wire logic [F:0]            px,
    input  wire logic [F:0]            py,
    input  wire logic signed [F+1:0]   qx,
    input  wire logic signed [F+1:0]   qy,
    output npd_pkg::npd_ctrl_t         ctrl_out,
    output logic [AW-1:0]              idx_out,
    output logic [2*F+4:0]             d2
);
    import npd_pkg::*;

    npd_ctrl_t         c1_reg;
    npd_ctrl_t         c2_reg;
    logic [AW-1:0]     i1_reg;
    logic [AW-1:0]     i2_reg;
    logic [F+1:0]      ax_reg;
    logic [F+1:0]      ay_reg;
    logic [2*F+3:0]    sx_reg;
    logic [2*F+3:0]    sy_reg;
    logic signed [F+2:0] dx;
    logic signed [F+2:0] dy;
    logic [F+2:0]      adx;
    logic [F+2:0]      ady;

    // Differences and their magnitudes.
    always_comb
    begin
        dx  = $signed({2'b00, px}) - (F+3)'(qx);
        dy  = $signed({2'b00, py}) - (F+3)'(qy);
        adx = dx[F+2] ? (F+3)'(-dx) : (F+3)'(dx);
        ady = dy[F+2] ? (F+3)'(-dy) : (F+3)'(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else
        begin
            c1_reg <= ctrl_in;
            c2_reg <= c1_reg;
        end
    end

    // Magnitude stage, then square stage.
    always_ff @(posedge clk)
    begin
        ax_reg <= adx[F+1:0];
        ay_reg <= ady[F+1:0];
        i1_reg <= idx_in;
        sx_reg <= ax_reg * ax_reg;
        sy_reg <= ay_reg * ay_reg;
        i2_reg <= i1_reg;
    end

    assign ctrl_out = c2_reg;
    assign idx_out  = i2_reg;
    assign d2       = {1'b0, sx_reg} + {1'b0, sy_reg};

endmodule

`default_nettype wire

// ===== sv/npd_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npd_sqrt_cell #(
    parameter int F = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             valid_in,
    input  wire logic [2*F-1:0]   n_in,
    input  wire logic [F+1:0]     rem_in,
    input  wire logic [F-1:0]     root_in,
    output logic                  valid_out,
    output logic [2*F-1:0]        n_out,
    output logic [F+1:0]          rem_out,
    output logic [F-1:0]          root_out
);

    logic [F+1:0] rem_sh;
    logic [F+1:0] trial;
    logic         fits;

    // One restoring square-root step: two radicand bits in, one root bit out.
    always_comb
    begin
        rem_sh = {rem_in[F-1:0], n_in[2*F-1:2*F-2]};
        trial  = {root_in, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        n_out    <= {n_in[2*F-3:0], 2'b00};
        rem_out  <= fits ? rem_sh - trial : rem_sh;
        root_out <= {root_in[F-2:0], fits};
    end

endmodule

`default_nettype wire

// ===== sv/nearest_point_distance_query.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest feature point query. Clear and append requests are taken while idle.
// A query walks the stored points one per cycle through a two-stage distance
// unit fed from a registered-read point memory, keeping the first minimum of
// the squared distance, then passes 25 times that minimum through a chain of
// FRAC_BITS square-root cells, or skips the root chain and reports 1.0 when
// the shade clamps to 1.0; an empty table answers without a scan.
// The result sits in an output register, so clear and append requests are
// still taken while it waits; the next query waits for that register.
module nearest_point_distance_query #(
    parameter int MAX_POINTS = 512,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire logic [1:0]               command,
    input  wire logic signed [FRAC_BITS+1:0] coord_x,
    input  wire logic signed [FRAC_BITS+1:0] coord_y,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic [FRAC_BITS:0]            shade,
    output logic [npd_pkg::INDEX_W-1:0]   nearest_index,
    output logic                          table_empty
);
    import npd_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         rd_cnt_reg;
    npd_ctrl_t             rd_ctrl_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic signed [F+1:0]   qx_reg, qy_reg;
    logic [2*F+4:0]        best_reg;
    logic [AW-1:0]         best_idx_reg;
    logic [F:0]            res_shade_reg;
    logic                  res_empty_reg;
    logic                  res_valid_reg;
    logic [F:0]            shade_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic                  empty_reg;

    logic                  accept;
    logic                  issue;
    logic                  wr_en;
    logic [F:0]            cx, cy;
    logic [2*F+1:0]        ram_rdata;
    npd_ctrl_t             d_ctrl;
    logic [AW-1:0]         d_idx;
    logic [2*F+4:0]        d2;
    logic [2*F+9:0]        scaled;
    logic                  chain_go;

    logic                  cv   [F+1];
    logic [2*F-1:0]        cn   [F+1];
    logic [F+1:0]          crem [F+1];
    logic [F-1:0]          croot[F+1];

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign wr_en     = accept && (command == CMD_APPEND) && (count_reg < CW'(MAX_POINTS));
    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg < count_reg);

    // Saturate appended coordinates into the unit square.
    always_comb
    begin
        if (coord_x[F+1])
            cx = '0;
        else if (coord_x[F:0] > ONE)
            cx = ONE;
        else
            cx = coord_x[F:0];
        if (coord_y[F+1])
            cy = '0;
        else if (coord_y[F:0] > ONE)
            cy = ONE;
        else
            cy = coord_y[F:0];
    end

    npd_ram #(
        .WIDTH (2*F+2),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_points (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata ({cx, cy}),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    npd_dist #(
        .F  (F),
        .AW (AW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (rd_ctrl_reg),
        .idx_in   (rd_idx_reg),
        .px       (ram_rdata[2*F+1:F+1]),
        .py       (ram_rdata[F:0]),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .ctrl_out (d_ctrl),
        .idx_out  (d_idx),
        .d2       (d2)
    );

    // 25 times the minimum, and the clamp test against 1.0 squared.
    assign scaled   = ({5'b0, best_reg} << 4) + ({5'b0, best_reg} << 3) + {5'b0, best_reg};
    assign chain_go = (state_reg == ST_LOAD) && (scaled < ((2*F+10)'(1) << (2*F)));

    // Square-root chain.
    assign cv[0]    = chain_go;
    assign cn[0]    = scaled[2*F-1:0];
    assign crem[0]  = '0;
    assign croot[0] = '0;

    for (genvar g = 0; g < F; g++)
    begin : g_cell
        npd_sqrt_cell #(
            .F (F)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (cv[g]),
            .n_in      (cn[g]),
            .rem_in    (crem[g]),
            .root_in   (croot[g]),
            .valid_out (cv[g+1]),
            .n_out     (cn[g+1]),
            .rem_out   (crem[g+1]),
            .root_out  (croot[g+1])
        );
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_QUERY))
                    state_next = (count_reg == '0) ? ST_OUT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (d_ctrl.valid && d_ctrl.last)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = chain_go ? ST_ROOT : ST_OUT;
            end
            ST_ROOT:
            begin
                if (cv[F])
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            rd_ctrl_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (command == CMD_CLEAR))
                count_reg <= '0;
            else if (wr_en)
                count_reg <= count_reg + CW'(1);
            if (accept)
                rd_cnt_reg <= '0;
            else if (issue)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            rd_ctrl_reg.valid <= issue;
            rd_ctrl_reg.first <= (rd_cnt_reg == '0);
            rd_ctrl_reg.last  <= (rd_cnt_reg == count_reg - CW'(1));
            if ((state_reg == ST_OUT) && (!res_valid_reg || res_ready))
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_cnt_reg[AW-1:0];
        if (accept && (command == CMD_QUERY))
        begin
            qx_reg        <= coord_x;
            qy_reg        <= coord_y;
            best_idx_reg  <= '0;
            res_shade_reg <= ONE;
            res_empty_reg <= (count_reg == '0);
        end
        if (d_ctrl.valid && (d_ctrl.first || (d2 < best_reg)))
        begin
            best_reg     <= d2;
            best_idx_reg <= d_idx;
        end
        if ((state_reg == ST_ROOT) && cv[F])
            res_shade_reg <= {1'b0, croot[F]};
        if ((state_reg == ST_OUT) && (!res_valid_reg || res_ready))
        begin
            shade_reg <= res_shade_reg;
            index_reg <= INDEX_W'(best_idx_reg);
            empty_reg <= res_empty_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign shade         = shade_reg;
    assign nearest_index = index_reg;
    assign table_empty   = empty_reg;

    // The point count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table size");

    // The scan never reads past the stored points.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg <= count_reg))
        else $error("scan address beyond point count");

    // An empty-table answer always carries full shade and index zero.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && table_empty) |-> ((shade == ONE) && (nearest_index == '0)))
        else $error("empty-table result malformed");

    // A query is launched into the root chain only from the load step.
    a_chain_launch: assert property (@(posedge clk) disable iff (!rst_n)
        cv[1] |-> ($past(state_reg) == ST_LOAD) && (state_reg == ST_ROOT))
        else $error("root chain launched outside a query");

endmodule

`default_nettype wire
